// ----- rtl/core/slbm_pkg.sv -----
package slbm_pkg;

	// widths of the streaming payloads, padded to whole bytes
	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 24;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 6;

	// serial shifter value when empty and control value forced by a reset write
	localparam logic [4:0] ShiftEmpty = 5'b10000;
	localparam logic [4:0] CtrlReset  = 5'b01100;

	// last serial bit before the collected value is loaded
	localparam logic [2:0] LastBitIdx = 3'd4;

	// reset values that follow from the register defaults
	localparam logic [3:0] LastPrgReset = 4'd1;
	localparam logic [4:0] ChrHiReset   = 5'd1;
	localparam logic [1:0] MirrorReset  = 2'd0;

	// one result item
	typedef struct packed {
		logic [4:0] chr_high_bank;
		logic [4:0] chr_low_bank;
		logic [3:0] prg_high_bank;
		logic [3:0] prg_low_bank;
		logic [1:0] mirror_mode;
	} result_t;

endpackage

// ----- rtl/core/serial_load_bank_mapper.sv -----
// a result is registered into the result queue when its write transfer is taken
// throughput: one write per cycle while the result queue has space; its two
//   entries let input go on for up to two writes while the output side stalls
// reset (arst_n low): shifter empty, control 01100, banks low 0 / high 1,
//   chr high bank 1, mirroring 0, last prg bank 1
module serial_load_bank_mapper
	import slbm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // addr[15:0], data[23:16]
	output logic                m_tvalid,
	input  logic                m_tready,
	// mirror_mode[1:0], prg_low_bank[5:2], prg_high_bank[9:6],
	// chr_low_bank[14:10], chr_high_bank[19:15], zero[23:20]
	output logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_addr,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic    fire;
	logic    space;
	result_t res;
	result_t head;

	assign s_tready = space;
	assign fire     = s_tvalid && space;

	// register state and next-result logic
	slbm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.addr     (s_tdata[15:0]),
		.data     (s_tdata[23:16]),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.res      (res)
	);

	// result queue towards the output side
	slbm_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.push_res (res),
		.space    (space),
		.avail    (m_tvalid),
		.take     (m_tready),
		.head     (head)
	);

	assign m_tdata = {{(OutDataW - $bits(result_t)){1'b0}}, head};

endmodule

// ----- rtl/core/slbm_core.sv -----
module slbm_core
	import slbm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [15:0]         addr,
	input  logic [7:0]          data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_addr,
	input  logic [CfgDataW-1:0] cfg_data,
	output result_t             res
);

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_PRG_COUNT = 2'd0,
		CFG_CHR_COUNT = 2'd1,
		CFG_MIRROR    = 2'd2,
		CFG_SPARE     = 2'd3
	} cfg_idx_t;

	// load target picked by address bits 14:13; control when address bit 15 is clear
	typedef enum logic [1:0] {
		TGT_CTRL = 2'd0,
		TGT_CHR0 = 2'd1,
		TGT_CHR1 = 2'd2,
		TGT_PRG  = 2'd3
	} target_t;

	// prg banking modes from control bits 3:2
	typedef enum logic [1:0] {
		PRG_32K_A   = 2'd0,
		PRG_32K_B   = 2'd1,
		PRG_FIX_LOW = 2'd2,
		PRG_FIX_HI  = 2'd3
	} prg_mode_t;

	logic [4:0] shifter_q;
	logic [2:0] bit_cnt_q;
	logic [4:0] ctrl_q;
	logic [4:0] chr0_q;
	logic [3:0] prg_lo_q;
	logic [3:0] prg_hi_q;
	logic [4:0] chr_hi_q;
	logic [1:0] mirror_q;
	logic [3:0] last_prg_q;

	logic [4:0] shifter_n;
	logic [2:0] bit_cnt_n;
	logic [4:0] ctrl_n;
	logic [4:0] chr0_n;
	logic [3:0] prg_lo_n;
	logic [3:0] prg_hi_n;
	logic [4:0] chr_hi_n;
	logic [1:0] mirror_n;

	logic [4:0] shifted;
	logic [3:0] last_prg_cfg;
	target_t    target;
	prg_mode_t  prg_mode;
	cfg_idx_t   cfg_idx;

	assign shifted      = {data[0], shifter_q[4:1]};
	assign target       = addr[15] ? target_t'(addr[14:13]) : TGT_CTRL;
	assign prg_mode     = prg_mode_t'(ctrl_q[3:2]);
	assign cfg_idx      = cfg_idx_t'(cfg_addr);
	assign last_prg_cfg = cfg_data[3:0] - 4'd1;

	// next state for one transfer
	always_comb begin
		shifter_n = shifted;
		bit_cnt_n = bit_cnt_q + 3'd1;
		ctrl_n    = ctrl_q;
		chr0_n    = chr0_q;
		prg_lo_n  = prg_lo_q;
		prg_hi_n  = prg_hi_q;
		chr_hi_n  = chr_hi_q;
		mirror_n  = mirror_q;
		if (data[7]) begin
			shifter_n = ShiftEmpty;
			bit_cnt_n = '0;
			ctrl_n    = CtrlReset;
		end else if (bit_cnt_q == LastBitIdx) begin
			shifter_n = ShiftEmpty;
			bit_cnt_n = '0;
			unique case (target)
				TGT_CTRL: begin
					ctrl_n   = shifted;
					mirror_n = shifted[1:0];
				end
				TGT_CHR0: begin
					chr0_n = shifted;
				end
				TGT_CHR1: begin
					if (ctrl_q[4]) begin
						chr_hi_n = shifted;
					end
				end
				TGT_PRG: begin
					unique case (prg_mode)
						PRG_32K_A, PRG_32K_B: begin
							prg_lo_n = {shifted[3:1], 1'b0};
							prg_hi_n = {shifted[3:1], 1'b1};
						end
						PRG_FIX_LOW: begin
							prg_lo_n = '0;
							prg_hi_n = shifted[3:0];
						end
						PRG_FIX_HI: begin
							prg_lo_n = shifted[3:0];
							prg_hi_n = last_prg_q;
						end
						default: begin
							prg_lo_n = prg_lo_q;
							prg_hi_n = prg_hi_q;
						end
					endcase
				end
				default: begin
					ctrl_n = ctrl_q;
				end
			endcase
		end
	end

	// result seen after this transfer
	always_comb begin
		res.mirror_mode   = mirror_n;
		res.prg_low_bank  = prg_lo_n;
		res.prg_high_bank = prg_hi_n;
		res.chr_low_bank  = chr0_n;
		res.chr_high_bank = chr_hi_n;
	end

	// mapper state and configuration reloads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shifter_q  <= ShiftEmpty;
			bit_cnt_q  <= '0;
			ctrl_q     <= CtrlReset;
			chr0_q     <= '0;
			prg_lo_q   <= '0;
			prg_hi_q   <= LastPrgReset;
			chr_hi_q   <= ChrHiReset;
			mirror_q   <= MirrorReset;
			last_prg_q <= LastPrgReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PRG_COUNT: begin
					last_prg_q <= last_prg_cfg;
					prg_hi_q   <= last_prg_cfg;
				end
				CFG_CHR_COUNT: begin
					chr_hi_q <= (cfg_data == 6'd1) ? 5'd0 : 5'd1;
				end
				CFG_MIRROR: begin
					mirror_q <= cfg_data[1:0];
				end
				default: begin
					mirror_q <= mirror_q;
				end
			endcase
		end else if (fire) begin
			shifter_q <= shifter_n;
			bit_cnt_q <= bit_cnt_n;
			ctrl_q    <= ctrl_n;
			chr0_q    <= chr0_n;
			prg_lo_q  <= prg_lo_n;
			prg_hi_q  <= prg_hi_n;
			chr_hi_q  <= chr_hi_n;
			mirror_q  <= mirror_n;
		end
	end

	// counter never passes the last serial bit
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= LastBitIdx)
		else $error("serial bit counter out of range");

	// a reset write empties the shifter
	a_reset_write: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg_we && data[7] |=> (bit_cnt_q == 3'd0) && (shifter_q == ShiftEmpty))
		else $error("reset write did not empty the shifter");

	// shifter empty whenever the counter is at zero
	a_shift_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_cnt_q == 3'd0) |-> (shifter_q == ShiftEmpty))
		else $error("shifter not empty at count zero");

endmodule

// ----- rtl/core/slbm_obuf.sv -----
module slbm_obuf
	import slbm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_res,
	output logic    space,
	output logic    avail,
	input  logic    take,
	output result_t head
);

	result_t    head_q;
	result_t    tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign space = (cnt_q != 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head  = head_q;
	assign pop   = avail && take;

	// two-entry result queue, head drives the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			priority if (push && pop) begin
				cnt_q <= cnt_q;
			end else if (push) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (push && pop) begin
			if (cnt_q == 2'd1) begin
				head_q <= push_res;
			end else begin
				head_q <= tail_q;
				tail_q <= push_res;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_res;
			end else begin
				tail_q <= push_res;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	// never pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2))
		else $error("result queue overflow");

	// occupancy stays within two entries
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	// a push into an empty queue shows up at the head next cycle
	a_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push && (cnt_q == 2'd0) |=> avail && (head_q == $past(push_res)))
		else $error("result lost on push into empty queue");

endmodule

// ----- tb/serial_load_bank_mapper_tb.sv -----
module serial_load_bank_mapper_tb;
	import slbm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] REG_PRG_COUNT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CHR_COUNT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MIRROR    = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_UNUSED    = 2'd3;

	// program window modes held in control bits 3:2
	localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

	// upper ends of the address quarters
	localparam logic [15:0] CTRL_TOP = 16'h9FFF;
	localparam logic [15:0] CHR0_TOP = 16'hBFFF;
	localparam logic [15:0] CHR1_TOP = 16'hDFFF;

	typedef enum int unsigned {
		TGT_CTRL,
		TGT_CHR0,
		TGT_CHR1,
		TGT_PRG
	} target_e;

	typedef struct {
		logic [15:0] addr;
		logic [7:0]  data;
	} cpu_write_t;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata  = '0;  // addr[15:0], data[23:16]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// mirror_mode[1:0], prg_low_bank[5:2], prg_high_bank[9:6],
	// chr_low_bank[14:10], chr_high_bank[19:15], zero[23:20]
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we   = 1'b0;
	logic [CfgIdxW-1:0]  cfg_addr = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	cpu_write_t  write_queue[$];
	result_t     expected_banks[$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned writes_made;
	int unsigned mismatch_count;

	// mapper state mirrored by the predictor
	logic [4:0] prg_count;
	logic [5:0] chr_count;
	logic [1:0] mirror_init;
	logic [4:0] shift_q;
	logic [2:0] bits_seen;
	logic [4:0] ctrl_q;
	logic [4:0] chr0_q;
	logic [4:0] chr1_q;
	logic [4:0] prg_q;
	logic [3:0] prg_lo;
	logic [3:0] prg_hi;
	logic [4:0] chr_hi;
	logic [1:0] mirror_q;

	serial_load_bank_mapper u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// applies one processor write to the mirrored state and returns the bank map
	function automatic result_t map_write(input logic [15:0] addr, input logic [7:0] data);
		logic [4:0] v;
		result_t    r;
		if (data[7]) begin
			shift_q   = ShiftEmpty;
			bits_seen = '0;
			ctrl_q    = CtrlReset;
		end else begin
			shift_q   = {data[0], shift_q[4:1]};
			bits_seen = bits_seen + 3'd1;
			if (bits_seen >= 3'd5) begin
				v = shift_q;
				if (addr <= CTRL_TOP) begin
					ctrl_q   = v;
					mirror_q = v[1:0];
				end else if (addr <= CHR0_TOP) begin
					chr0_q = v;
				end else if (addr <= CHR1_TOP) begin
					if (ctrl_q[4]) begin
						chr1_q = v;
						chr_hi = v;
					end
				end else begin
					prg_q = v;
					case (ctrl_q[3:2])
						PRG_MODE_FIX_LOW: begin
							prg_lo = '0;
							prg_hi = v[3:0];
						end
						PRG_MODE_FIX_HIGH: begin
							prg_lo = v[3:0];
							prg_hi = 4'(prg_count - 5'd1);
						end
						default: begin
							prg_lo = v[3:0] & 4'b1110;
							prg_hi = prg_lo + 4'd1;
						end
					endcase
				end
				shift_q   = ShiftEmpty;
				bits_seen = '0;
			end
		end
		r.mirror_mode   = mirror_q;
		r.prg_low_bank  = prg_lo;
		r.prg_high_bank = prg_hi;
		r.chr_low_bank  = chr0_q;
		r.chr_high_bank = chr_hi;
		return r;
	endfunction

	// sender: presents queued writes, predicting each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_banks.push_back(map_write(s_tdata[15:0], s_tdata[23:16]));
			end
			if (!s_tvalid || s_tready) begin
				if (write_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {write_queue[0].data, write_queue[0].addr};
					void'(write_queue.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure and check of each result transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (expected_banks.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transfer: %h", m_tdata);
				end else begin
					if (m_tdata[$bits(result_t)-1:0] !== expected_banks[0]) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("mismatch: expected mir %0d prg %0d/%0d chr %0d/%0d",
								expected_banks[0].mirror_mode,
								expected_banks[0].prg_low_bank,
								expected_banks[0].prg_high_bank,
								expected_banks[0].chr_low_bank,
								expected_banks[0].chr_high_bank);
							$display(", got mir %0d prg %0d/%0d chr %0d/%0d",
								m_tdata[1:0], m_tdata[5:2], m_tdata[9:6],
								m_tdata[14:10], m_tdata[19:15]);
						end
					end
					void'(expected_banks.pop_front());
				end
			end
		end
	end

	task automatic push_write(input logic [15:0] addr, input logic [7:0] data);
		cpu_write_t w;
		w.addr = addr;
		w.data = data;
		write_queue.push_back(w);
		writes_made++;
	endtask

	// five serial bits, lowest first; only the address of the last one matters
	task automatic push_load(input logic [15:0] last_addr, input logic [4:0] value,
		input bit rand_lead);
		for (int i = 0; i < 5; i++) begin
			push_write((i == 4 || !rand_lead) ? last_addr : 16'($urandom),
				{1'b0, 6'($urandom), value[i]});
		end
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_PRG_COUNT: begin
				prg_count = val[4:0];
				prg_hi    = 4'(prg_count - 5'd1);
			end
			REG_CHR_COUNT: begin
				chr_count = val;
				chr_hi    = (chr_count == 6'd1) ? 5'd0 : 5'd1;
			end
			REG_MIRROR: begin
				mirror_init = val[1:0];
				mirror_q    = mirror_init;
			end
			default: ;
		endcase
	endtask

	task automatic set_mapping(input logic [4:0] prg_n, input logic [5:0] chr_n,
		input logic [1:0] mir);
		write_reg(REG_PRG_COUNT, {1'b0, prg_n});
		write_reg(REG_CHR_COUNT, chr_n);
		write_reg(REG_MIRROR, {4'd0, mir});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// block until every write has been taken and every result checked
	task automatic wait_drained();
		while (write_queue.size() != 0 || s_tvalid || expected_banks.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// mostly complete five-bit loads, with stray writes and cut-short loads mixed in
	task automatic random_writes(input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned count);
		int unsigned goal;
		int unsigned pick;
		target_e     tgt;
		logic [15:0] last_addr;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		goal = writes_made + count;
		while (writes_made < goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				if (pick == 0)
					push_write(16'($urandom), {1'b1, 7'($urandom)});
				tgt = target_e'($urandom_range(0, 3));
				if ($urandom_range(0, 15) == 0)
					last_addr = {1'b0, 15'($urandom)};
				else
					last_addr = {1'b1, 2'(tgt), 13'($urandom)};
				push_load(last_addr, 5'($urandom), 1'b1);
			end else if (pick < 9) begin
				push_write(16'($urandom), 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					push_write(16'($urandom), {1'b0, 7'($urandom)});
				push_write(16'($urandom), {1'b1, 7'($urandom)});
			end
		end
		wait_drained();
	endtask

	// main sequence
	initial begin
		mismatch_count = 0;
		writes_made    = 0;
		send_idle_pct  = 28;
		recv_idle_pct  = 81;
		prg_count      = 5'd2;
		chr_count      = 6'd2;
		mirror_init    = 2'd0;
		shift_q        = ShiftEmpty;
		bits_seen      = '0;
		ctrl_q         = CtrlReset;
		chr0_q         = '0;
		chr1_q         = '0;
		prg_q          = '0;
		prg_lo         = '0;
		prg_hi         = LastPrgReset;
		chr_hi         = ChrHiReset;
		mirror_q       = MirrorReset;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset write, control, chr1 and prg targets, a broken load and an address below the range
		push_write(16'h8000, 8'h80);
		push_load(16'h8000, 5'h1F, 1'b0);
		push_load(16'hDFFF, 5'h15, 1'b0);
		push_load(16'hFFFF, 5'h1F, 1'b0);
		push_write(16'hA000, 8'h01);
		push_write(16'hA000, 8'h7F);
		push_write(16'hBFFF, 8'hFF);
		push_load(16'h7FFF, 5'h08, 1'b0);
		random_writes(28, 81, 50);

		// largest counts and mirroring
		set_mapping(5'd16, 6'd32, 2'd3);
		random_writes(28, 81, 75);

		// single banks, plus a write to the unused index
		set_mapping(5'd1, 6'd1, 2'd1);
		write_reg(REG_UNUSED, 6'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
		random_writes(81, 28, 75);

		// zero bank counts
		set_mapping(5'd0, 6'd0, 2'd2);
		random_writes(81, 28, 75);

		set_mapping(5'($urandom_range(1, 16)), 6'($urandom_range(0, 32)),
			2'($urandom_range(0, 3)));
		random_writes(0, 0, 75);

		set_mapping(5'($urandom_range(1, 16)), 6'($urandom_range(0, 32)),
			2'($urandom_range(0, 3)));
		random_writes(0, 0, 75);

		if (expected_banks.size() != 0) begin
			mismatch_count++;
			$display("%0d expected results never arrived", expected_banks.size());
		end
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/slbm_pkg.sv
rtl/core/slbm_core.sv
rtl/core/slbm_obuf.sv
rtl/core/serial_load_bank_mapper.sv
tb/serial_load_bank_mapper_tb.sv
